// ===== rtl/gpsc_pkg.sv =====
package gpsc_pkg;

  localparam int unsigned Ports = 4;
  localparam int unsigned PortW = 2;
  localparam int unsigned PakBytes = 32768;
  localparam int unsigned PakAw = 15;
  localparam int unsigned MemAw = PortW + PakAw;
  localparam int unsigned BlockBytes = 32;
  localparam int unsigned FrameDepth = BlockBytes + 3;

  localparam logic [7:0] CmdStatus = 8'h00;
  localparam logic [7:0] CmdPoll = 8'h01;
  localparam logic [7:0] CmdRead = 8'h02;
  localparam logic [7:0] CmdWrite = 8'h03;
  localparam logic [7:0] CmdReset = 8'hff;

  typedef enum logic [3:0] {
    StIdle,
    StClear,
    StDecode,
    StAcrc,
    StStatus,
    StPoll,
    StRdFetch,
    StRdWait,
    StRdEmit,
    StRdCrc,
    StWrFetch,
    StWrStep,
    StWrEmit,
    StNoResp
  } state_e;

  // one shift step of the address check (poly 0x15)
  function automatic logic [4:0] acrc_step(logic [4:0] c, logic b);
    logic [4:0] n;
    n = {c[3:0], b};
    if (c[4]) n = n ^ 5'h15;
    return n;
  endfunction

  // one byte (8 steps) of the data check (poly 0x85)
  function automatic logic [7:0] dcrc_byte(logic [7:0] c, logic [7:0] d);
    logic [7:0] n;
    n = c;
    for (int b = 7; b >= 0; b--) begin
      n = n[7] ? ({n[6:0], d[b]} ^ 8'h85) : {n[6:0], d[b]};
    end
    return n;
  endfunction

endpackage

// ===== rtl/gpsc_pak_mem.sv =====
module gpsc_pak_mem (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [gpsc_pkg::MemAw-1:0] addr_i,
  input  logic [7:0]                wdata_i,
  output logic [7:0]                rdata_o
);

  logic [7:0] mem_q [2**gpsc_pkg::MemAw];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end

endmodule

// ===== rtl/gpsc_crc_unit.sv =====
module gpsc_crc_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       clr_i,
  input  logic       byte_en_i,
  input  logic [7:0] byte_i,
  input  logic       bit_en_i,
  input  logic       bit_i,
  output logic [7:0] dcrc_o,
  output logic [4:0] acrc_o
);

  logic [7:0] dcrc_q, dcrc_d;
  logic [4:0] acrc_q, acrc_d;

  always_comb begin
    dcrc_d = dcrc_q;
    acrc_d = acrc_q;
    if (clr_i) begin
      dcrc_d = '0;
      acrc_d = '0;
    end else begin
      if (byte_en_i) dcrc_d = gpsc_pkg::dcrc_byte(dcrc_q, byte_i);
      if (bit_en_i) acrc_d = gpsc_pkg::acrc_step(acrc_q, bit_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcrc_q <= '0;
      acrc_q <= '0;
    end else begin
      dcrc_q <= dcrc_d;
      acrc_q <= acrc_d;
    end
  end

  assign dcrc_o = dcrc_q;
  assign acrc_o = acrc_q;

endmodule

// ===== rtl/game_pad_serial_command_responder.sv =====
// a state update or a non-final frame byte is taken while idle; after the final byte, status,
// poll and no-response replies follow a decode state at one byte per cycle, pak read follows a
// 16-step address check and sends each byte after a fetch and a wait state, and pak write answers
// once every stored byte has gone through a fetch and a step state on the single memory port
// reset: the pak store is swept to zero with busy high
// the receiver cannot stall; results appear for one cycle with reply_valid_o
module game_pad_serial_command_responder (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic              func_i,
  input  logic [1:0]        port_i,
  input  logic [7:0]        byte_in_i,
  input  logic              last_byte_i,
  input  logic [7:0]        recv_len_i,
  input  logic [15:0]       buttons_i,
  input  logic signed [7:0] stick_x_i,
  input  logic signed [7:0] stick_y_i,
  input  logic              connected_i,
  input  logic              pak_present_i,
  output logic              reply_valid_o,
  output logic [7:0]        reply_byte_o,
  output logic              reply_last_o,
  output logic              responded_o,
  output logic              overflow_o
);

  localparam int unsigned MemAw = gpsc_pkg::MemAw;
  localparam int unsigned PakAw = gpsc_pkg::PakAw;

  gpsc_pkg::state_e state_q, state_d;

  // command and address bytes, then the data bytes of the frame
  logic [7:0]  hdr_q [3];
  logic [7:0]  frame_q [gpsc_pkg::BlockBytes];
  logic [7:0]  sent_q, sent_d;
  logic [15:0] btn_q [gpsc_pkg::Ports];
  logic [7:0]  sx_q [gpsc_pkg::Ports];
  logic [7:0]  sy_q [gpsc_pkg::Ports];
  logic [gpsc_pkg::Ports-1:0] conn_q, pak_q, chg_q;
  logic [MemAw-1:0] clr_addr_q, clr_addr_d;

  logic [1:0]  port_q, port_d;
  logic [7:0]  recv_q, recv_d;
  logic [7:0]  send_q, send_d;
  logic [5:0]  idx_q, idx_d;
  logic        ok_q, ok_d;
  logic [15:0] enc_q, enc_d;

  // memory and crc controls
  logic             mem_we;
  logic [MemAw-1:0] mem_addr;
  logic [7:0]       mem_wdata, mem_rdata;
  logic             crc_clr, crc_byte_en, crc_bit_en, crc_bit;
  logic [7:0]       crc_byte, dcrc;
  logic [4:0]       acrc;

  logic       take;
  logic [7:0] cmd;
  logic       pconn;
  logic [16:0] pos;
  logic       in_range;
  logic [7:0] rd_byte;
  logic [5:0] dl;
  logic [5:0] rd_n;

  assign take = start && !busy;
  assign cmd = hdr_q[0];
  assign pconn = conn_q[port_q];
  assign pos = {1'b0, enc_q[15:5], 5'b0} + {12'b0, idx_q[4:0]};
  assign in_range = (pos < 17'(gpsc_pkg::PakBytes));
  assign rd_byte = (ok_q && in_range) ? mem_rdata : 8'h00;
  assign dl = (send_q - 8'd3 > 8'd32) ? 6'd32 : 6'(send_q - 8'd3);
  assign rd_n = (recv_q > 8'd33) ? 6'd33 : recv_q[5:0];

  // final address check step folded with the 16th bit
  function automatic logic [4:0] crc_check(logic [4:0] c);
    return gpsc_pkg::acrc_step(c, 1'b0);
  endfunction

  gpsc_pak_mem u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .addr_i (mem_addr),
    .wdata_i(mem_wdata),
    .rdata_o(mem_rdata)
  );

  gpsc_crc_unit u_crc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .clr_i    (crc_clr),
    .byte_en_i(crc_byte_en),
    .byte_i   (crc_byte),
    .bit_en_i (crc_bit_en),
    .bit_i    (crc_bit),
    .dcrc_o   (dcrc),
    .acrc_o   (acrc)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gpsc_pkg::StClear: begin
        if (&clr_addr_q) state_d = gpsc_pkg::StIdle;
      end
      gpsc_pkg::StIdle: begin
        if (take && func_i && last_byte_i) state_d = gpsc_pkg::StDecode;
      end
      gpsc_pkg::StDecode: begin
        if (!pconn) state_d = gpsc_pkg::StNoResp;
        else if (cmd == gpsc_pkg::CmdStatus || cmd == gpsc_pkg::CmdReset)
          state_d = gpsc_pkg::StStatus;
        else if (cmd == gpsc_pkg::CmdPoll) state_d = gpsc_pkg::StPoll;
        else if ((cmd == gpsc_pkg::CmdRead && send_q >= 8'd3 && recv_q != 0) ||
                 (cmd == gpsc_pkg::CmdWrite && send_q >= 8'd4 && recv_q != 0))
          state_d = gpsc_pkg::StAcrc;
        else state_d = gpsc_pkg::StNoResp;
      end
      gpsc_pkg::StAcrc: begin
        if (idx_q == 6'd15)
          state_d = (cmd == gpsc_pkg::CmdRead) ? gpsc_pkg::StRdFetch
                                               : gpsc_pkg::StWrFetch;
      end
      gpsc_pkg::StStatus, gpsc_pkg::StPoll: begin
        if ((state_q == gpsc_pkg::StStatus && idx_q == 6'd2) || idx_q == 6'd3)
          state_d = gpsc_pkg::StIdle;
      end
      gpsc_pkg::StRdFetch: state_d = gpsc_pkg::StRdWait;
      gpsc_pkg::StRdWait: state_d = gpsc_pkg::StRdEmit;
      gpsc_pkg::StRdEmit: begin
        if (idx_q + 6'd1 == rd_n) state_d = gpsc_pkg::StIdle;
        else if (idx_q == 6'd31) state_d = gpsc_pkg::StRdCrc;
        else state_d = gpsc_pkg::StRdFetch;
      end
      gpsc_pkg::StRdCrc: state_d = gpsc_pkg::StIdle;
      gpsc_pkg::StWrFetch: begin
        if (idx_q == dl) state_d = gpsc_pkg::StWrEmit;
        else state_d = gpsc_pkg::StWrStep;
      end
      gpsc_pkg::StWrStep: state_d = gpsc_pkg::StWrFetch;
      gpsc_pkg::StWrEmit, gpsc_pkg::StNoResp: state_d = gpsc_pkg::StIdle;
      default: state_d = gpsc_pkg::StIdle;
    endcase
  end

  // outputs and datapath controls
  always_comb begin
    busy = (state_q != gpsc_pkg::StIdle);
    reply_valid_o = 1'b0;
    reply_byte_o = 8'h00;
    reply_last_o = 1'b0;
    responded_o = 1'b1;
    overflow_o = 1'b0;
    mem_we = 1'b0;
    mem_addr = {port_q, pos[PakAw-1:0]};
    mem_wdata = frame_q[idx_q[4:0]];
    crc_clr = 1'b0;
    crc_byte_en = 1'b0;
    crc_byte = 8'h00;
    crc_bit_en = 1'b0;
    crc_bit = enc_q[4'(15 - idx_q[3:0])];
    unique case (state_q)
      gpsc_pkg::StClear: begin
        mem_we = 1'b1;
        mem_addr = clr_addr_q;
        mem_wdata = 8'h00;
      end
      gpsc_pkg::StDecode: crc_clr = 1'b1;
      gpsc_pkg::StAcrc: crc_bit_en = 1'b1;
      gpsc_pkg::StStatus: begin
        reply_valid_o = 1'b1;
        reply_last_o = (idx_q == 6'd2);
        if (idx_q == 6'd0) reply_byte_o = 8'h05;
        else if (idx_q == 6'd2)
          reply_byte_o = pak_q[port_q] ? (chg_q[port_q] ? 8'h03 : 8'h01) : 8'h02;
      end
      gpsc_pkg::StPoll: begin
        reply_valid_o = 1'b1;
        reply_last_o = (idx_q == 6'd3);
        overflow_o = (recv_q > 8'd4);
        case (idx_q[1:0])
          2'd0: reply_byte_o = btn_q[port_q][15:8];
          2'd1: reply_byte_o = btn_q[port_q][7:0];
          2'd2: reply_byte_o = sx_q[port_q];
          default: reply_byte_o = sy_q[port_q];
        endcase
      end
      gpsc_pkg::StRdEmit: begin
        reply_valid_o = 1'b1;
        reply_byte_o = rd_byte;
        reply_last_o = (idx_q + 6'd1 == rd_n);
        crc_byte_en = 1'b1;
        crc_byte = rd_byte;
      end
      gpsc_pkg::StRdCrc: begin
        reply_valid_o = 1'b1;
        reply_last_o = 1'b1;
        reply_byte_o = gpsc_pkg::dcrc_byte(dcrc, 8'h00) ^ {8{!ok_q}};
      end
      gpsc_pkg::StWrStep: begin
        mem_we = ok_q && in_range && (enc_q[15:5] != 11'h400);
        crc_byte_en = 1'b1;
        crc_byte = frame_q[idx_q[4:0]];
      end
      gpsc_pkg::StWrEmit: begin
        reply_valid_o = 1'b1;
        reply_last_o = 1'b1;
        reply_byte_o = ((dl == 6'd32) ? gpsc_pkg::dcrc_byte(dcrc, 8'h00) : 8'h00)
                       ^ {8{!ok_q}};
      end
      gpsc_pkg::StNoResp: begin
        reply_valid_o = 1'b1;
        reply_last_o = 1'b1;
        responded_o = 1'b0;
      end
      default: ;
    endcase
  end

  // sequencing registers
  always_comb begin
    port_d = port_q;
    recv_d = recv_q;
    send_d = send_q;
    idx_d = idx_q;
    ok_d = ok_q;
    enc_d = enc_q;
    sent_d = sent_q;
    clr_addr_d = clr_addr_q + MemAw'(1);
    case (state_q)
      gpsc_pkg::StIdle: begin
        idx_d = '0;
        if (take && func_i) begin
          sent_d = (sent_q == 8'hff) ? sent_q : sent_q + 8'd1;
          if (last_byte_i) begin
            send_d = (sent_q == 8'hff) ? sent_q : sent_q + 8'd1;
            sent_d = '0;
            port_d = port_i;
            recv_d = recv_len_i;
          end
        end
      end
      gpsc_pkg::StDecode: begin
        enc_d = {hdr_q[1], hdr_q[2]};
        enc_d[4:0] = 5'h0;
        idx_d = '0;
      end
      gpsc_pkg::StAcrc: begin
        idx_d = idx_q + 6'd1;
        if (idx_q == 6'd15) begin
          idx_d = '0;
          ok_d = pak_q[port_q] && !chg_q[port_q] && (hdr_q[2][4:0] == crc_check(acrc));
        end
      end
      gpsc_pkg::StStatus, gpsc_pkg::StPoll, gpsc_pkg::StRdEmit, gpsc_pkg::StWrStep:
        idx_d = idx_q + 6'd1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gpsc_pkg::StClear;
      clr_addr_q <= '0;
      sent_q <= '0;
      conn_q <= '0;
      pak_q <= '0;
      chg_q <= '0;
      port_q <= '0;
      recv_q <= '0;
      send_q <= '0;
      idx_q <= '0;
      ok_q <= 1'b0;
      enc_q <= '0;
      for (int i = 0; i < gpsc_pkg::Ports; i++) begin
        btn_q[i] <= '0;
        sx_q[i] <= '0;
        sy_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      clr_addr_q <= clr_addr_d;
      sent_q <= sent_d;
      port_q <= port_d;
      recv_q <= recv_d;
      send_q <= send_d;
      idx_q <= idx_d;
      ok_q <= ok_d;
      enc_q <= enc_d;
      if (state_q == gpsc_pkg::StStatus && idx_q == 6'd2) chg_q[port_q] <= 1'b0;
      if (take && !func_i) begin
        if (pak_present_i != pak_q[port_i] ||
            (!conn_q[port_i] && connected_i && pak_present_i))
          chg_q[port_i] <= 1'b1;
        btn_q[port_i] <= buttons_i;
        sx_q[port_i] <= stick_x_i;
        sy_q[port_i] <= stick_y_i;
        conn_q[port_i] <= connected_i;
        pak_q[port_i] <= pak_present_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && func_i) begin
      if (sent_q < 8'd3) hdr_q[sent_q[1:0]] <= byte_in_i;
      else if (sent_q < 8'(gpsc_pkg::FrameDepth)) frame_q[5'(sent_q - 8'd3)] <= byte_in_i;
    end
  end

endmodule
